[rtl/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// cfp_pkg: shared definitions of the frame parser
// Phase codes, queue operation codes, result kinds, register indexes and the
// CRC-16-CCITT byte update used by the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0]  START_BYTE_RESET  = 8'hAA;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd260;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Depth of the queue between the front and the back end.
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE  = 2'd0,
        CFG_MAX_PAYLOAD = 2'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_CMD  = 4'd1,
        PH_SEQH = 4'd2,
        PH_SEQL = 4'd3,
        PH_LENH = 4'd4,
        PH_LENL = 4'd5,
        PH_DATA = 4'd6,
        PH_CRCH = 4'd7,
        PH_CRCL = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    // Work handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,   // reload the running CRC
        OP_UPDATE = 2'd1,   // fold a header byte into the CRC
        OP_DATA   = 2'd2,   // fold a payload byte in and pass it out
        OP_CHECK  = 2'd3    // compare the received CRC and report
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [15:0] idx;
        logic [7:0]  cmd;
        logic [15:0] seq;
        logic [15:0] len;
        logic [15:0] frame_crc;
    } q_entry_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/cfp_byte_if.sv]
// ----------------------------------------------------------------------------
// cfp_byte_if: received byte channel
// Carries one byte of the serial stream per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/cfp_result_if.sv]
// ----------------------------------------------------------------------------
// cfp_result_if: parser result channel
// Carries a payload byte or an end-of-frame report per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_cmd;
    logic [15:0] frame_seq;
    logic [15:0] frame_len;

    modport source (output valid, output kind, output payload_byte,
                    output payload_index, output frame_cmd, output frame_seq,
                    output frame_len, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input payload_index, input frame_cmd, input frame_seq,
                    input frame_len, output ready);
endinterface

`default_nettype wire

[rtl/cfp_cfg_if.sv]
// ----------------------------------------------------------------------------
// cfp_cfg_if: configuration write channel
// Carries a register index and write data per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cfp_pkg::CFG_IDX_W-1:0]  index;
    logic [cfp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/cfp_front.sv]
// ----------------------------------------------------------------------------
// cfp_front: frame phase tracker
// Accepts received bytes, walks the frame layout and hands CRC and result
// work to the back end through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    cfp_byte_if.sink               rx,
    input  wire logic [7:0]        start_byte,
    input  wire logic [15:0]       max_payload,
    output cfp_pkg::q_entry_t      push_entry,
    output logic                   push_valid,
    input  wire logic              push_ready
);

    cfp_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     count_reg, count_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [15:0]     seq_reg, seq_next;
    logic [15:0]     len_reg, len_next;
    logic [7:0]      crch_reg, crch_next;
    logic            in_fire;
    logic [15:0]     count_inc;
    logic [15:0]     len_full;

    assign rx.ready  = push_ready;
    assign in_fire   = rx.valid && rx.ready;
    assign count_inc = count_reg + 16'd1;
    assign len_full  = {len_reg[15:8], rx.rx_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cfp_pkg::PH_HUNT;
            count_reg <= '0;
            cmd_reg   <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            crch_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            cmd_reg   <= cmd_next;
            seq_reg   <= seq_next;
            len_reg   <= len_next;
            crch_reg  <= crch_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        crch_next  = crch_reg;
        push_valid = 1'b0;
        push_entry.op        = cfp_pkg::OP_UPDATE;
        push_entry.data      = rx.rx_byte;
        push_entry.idx       = count_reg;
        push_entry.cmd       = cmd_reg;
        push_entry.seq       = seq_reg;
        push_entry.len       = len_reg;
        push_entry.frame_crc = {crch_reg, rx.rx_byte};
        if (in_fire)
        begin
            unique case (phase_reg)
                cfp_pkg::PH_HUNT:
                begin
                    if (rx.rx_byte == start_byte)
                    begin
                        push_valid    = 1'b1;
                        push_entry.op = cfp_pkg::OP_INIT;
                        count_next    = '0;
                        phase_next    = cfp_pkg::PH_CMD;
                    end
                end
                cfp_pkg::PH_CMD:
                begin
                    push_valid = 1'b1;
                    cmd_next   = rx.rx_byte;
                    phase_next = cfp_pkg::PH_SEQH;
                end
                cfp_pkg::PH_SEQH:
                begin
                    push_valid = 1'b1;
                    seq_next   = {rx.rx_byte, 8'h00};
                    phase_next = cfp_pkg::PH_SEQL;
                end
                cfp_pkg::PH_SEQL:
                begin
                    push_valid = 1'b1;
                    seq_next   = {seq_reg[15:8], rx.rx_byte};
                    phase_next = cfp_pkg::PH_LENH;
                end
                cfp_pkg::PH_LENH:
                begin
                    push_valid = 1'b1;
                    len_next   = {rx.rx_byte, 8'h00};
                    phase_next = cfp_pkg::PH_LENL;
                end
                cfp_pkg::PH_LENL:
                begin
                    push_valid = 1'b1;
                    len_next   = len_full;
                    count_next = '0;
                    if (len_full > max_payload)
                    begin
                        phase_next = cfp_pkg::PH_HUNT;
                    end
                    else if (len_full == 16'd0)
                    begin
                        phase_next = cfp_pkg::PH_CRCH;
                    end
                    else
                    begin
                        phase_next = cfp_pkg::PH_DATA;
                    end
                end
                cfp_pkg::PH_DATA:
                begin
                    push_valid    = 1'b1;
                    push_entry.op = cfp_pkg::OP_DATA;
                    count_next    = count_inc;
                    if (count_inc >= len_reg)
                    begin
                        phase_next = cfp_pkg::PH_CRCH;
                    end
                end
                cfp_pkg::PH_CRCH:
                begin
                    crch_next  = rx.rx_byte;
                    phase_next = cfp_pkg::PH_CRCL;
                end
                cfp_pkg::PH_CRCL:
                begin
                    push_valid    = 1'b1;
                    push_entry.op = cfp_pkg::OP_CHECK;
                    phase_next    = cfp_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = cfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // The payload counter starts from zero whenever a frame enters its data.
    a_data_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != cfp_pkg::PH_DATA) ##1 (phase_reg == cfp_pkg::PH_DATA)
        |-> (count_reg == 16'd0))
        else $error("payload counter not cleared on entry to data");

endmodule

`default_nettype wire

[rtl/cfp_queue.sv]
// ----------------------------------------------------------------------------
// cfp_queue: work queue between front and back end
// A short first-in first-out store of work entries.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfp_pkg::q_entry_t push_entry,
    input  wire logic              push_valid,
    output logic                   push_ready,
    output cfp_pkg::q_entry_t      pop_entry,
    output logic                   pop_valid,
    input  wire logic              pop_ready
);

    localparam int unsigned PTR_W = (cfp_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(cfp_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(cfp_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(cfp_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(cfp_pkg::QUEUE_DEPTH);

    cfp_pkg::q_entry_t mem [cfp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue fill count beyond depth");

    a_fill_tracks_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue fill count missed a push");

endmodule

`default_nettype wire

[rtl/cfp_back.sv]
// ----------------------------------------------------------------------------
// cfp_back: CRC engine and result stage
// Carries out queued work: keeps the running CRC, and loads payload bytes
// and end-of-frame reports into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfp_pkg::q_entry_t pop_entry,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    cfp_result_if.source           res
);

    logic [15:0]     crc_reg, crc_next;
    logic            out_valid_reg, out_valid_next;
    cfp_pkg::kind_t  kind_reg, kind_next;
    logic [7:0]      byte_reg, byte_next;
    logic [15:0]     idx_reg, idx_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [15:0]     seq_reg, seq_next;
    logic [15:0]     len_reg, len_next;
    logic            emits;
    logic            out_free;
    logic            pop_fire;

    assign emits     = (pop_entry.op == cfp_pkg::OP_DATA) ||
                       (pop_entry.op == cfp_pkg::OP_CHECK);
    assign out_free  = !out_valid_reg || res.ready;
    assign pop_ready = !emits || out_free;
    assign pop_fire  = pop_valid && pop_ready;

    always_comb
    begin
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !res.ready;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        seq_next       = seq_reg;
        len_next       = len_reg;
        if (pop_fire)
        begin
            unique case (pop_entry.op)
                cfp_pkg::OP_INIT:
                begin
                    crc_next = cfp_pkg::CRC_INIT;
                end
                cfp_pkg::OP_UPDATE:
                begin
                    crc_next = cfp_pkg::crc_byte(crc_reg, pop_entry.data);
                end
                cfp_pkg::OP_DATA:
                begin
                    crc_next       = cfp_pkg::crc_byte(crc_reg, pop_entry.data);
                    out_valid_next = 1'b1;
                    kind_next      = cfp_pkg::KIND_PAYLOAD;
                    byte_next      = pop_entry.data;
                    idx_next       = pop_entry.idx;
                    cmd_next       = pop_entry.cmd;
                    seq_next       = pop_entry.seq;
                    len_next       = pop_entry.len;
                end
                cfp_pkg::OP_CHECK:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = (pop_entry.frame_crc == crc_reg) ?
                                     cfp_pkg::KIND_GOOD : cfp_pkg::KIND_BAD;
                    byte_next      = '0;
                    idx_next       = '0;
                    cmd_next       = pop_entry.cmd;
                    seq_next       = pop_entry.seq;
                    len_next       = pop_entry.len;
                end
                default:
                begin
                    crc_next = crc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= cfp_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        idx_reg  <= idx_next;
        cmd_reg  <= cmd_next;
        seq_reg  <= seq_next;
        len_reg  <= len_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.kind          = kind_reg;
    assign res.payload_byte  = byte_reg;
    assign res.payload_index = idx_reg;
    assign res.frame_cmd     = cmd_reg;
    assign res.frame_seq     = seq_reg;
    assign res.frame_len     = len_reg;

    a_init_reloads_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_fire && (pop_entry.op == cfp_pkg::OP_INIT)) |=>
        (crc_reg == cfp_pkg::CRC_INIT))
        else $error("start of frame did not reload the CRC");

endmodule

`default_nettype wire

[rtl/crc16_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// crc16_frame_parser_unit: SOF/length/CRC-16 frame parser
// Deframes SOF, CMD, SEQ, LEN, DATA, CRC16 frames from a byte stream.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle for as long as the
// result side keeps up, and passes each payload byte out as it arrives,
// followed by a frame-good or CRC-error report on the last CRC byte. The
// front end tracks the frame layout and captures CMD, SEQ and LEN; the back
// end folds each byte into the CRC-16-CCITT (polynomial 0x1021, initial
// value 0xFFFF, most significant bit first), and that byte-wide CRC
// update sets the clock period of the block. A two-entry work queue sits
// between the two, so a byte is normally accepted while an earlier result
// still waits in the output register; a result passes through a queue
// entry and then the output register. Frames whose LEN exceeds the
// maximum are dropped without any report, so a consumer must discard the
// payload of a frame that does not end in a good-CRC report. Configuration
// transfers are always taken and must only be made while the parser is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_parser_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cfp_cfg_if.sink       cfg,
    cfp_byte_if.sink      rx,
    cfp_result_if.source  res
);

    // Configuration registers.
    logic [7:0]  start_byte_reg;
    logic [15:0] max_payload_reg;
    logic        cfg_fire;

    // Work queue links.
    cfp_pkg::q_entry_t push_entry;
    logic              push_valid;
    logic              push_ready;
    cfp_pkg::q_entry_t pop_entry;
    logic              pop_valid;
    logic              pop_ready;

    // The register file never stalls a write; unknown indexes are ignored.
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= cfp_pkg::START_BYTE_RESET;
            max_payload_reg <= cfp_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_fire)
        begin
            if (cfg.index == cfp_pkg::CFG_START_BYTE)
            begin
                start_byte_reg <= cfg.data[7:0];
            end
            else if (cfg.index == cfp_pkg::CFG_MAX_PAYLOAD)
            begin
                max_payload_reg <= cfg.data[15:0];
            end
        end
    end

    // Front end: follows the frame layout and posts work for each frame byte except the high CRC byte.
    cfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .start_byte  (start_byte_reg),
        .max_payload (max_payload_reg),
        .push_entry  (push_entry),
        .push_valid  (push_valid),
        .push_ready  (push_ready)
    );

    // Work queue: lets the front end run on while a result is stalled.
    cfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // Back end: running CRC and the result output register.
    cfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .res       (res)
    );

endmodule

`default_nettype wire
